/* src/sapc_pkg.sv */
// sapc_pkg: constants, codes and shared types of the servo angle to pwm count block
// used by the channel interfaces and every module under src
package sapc_pkg;

    // block constants
    localparam int     CHANNEL_COUNT  = 16;
    localparam int     PWM_FREQ_HZ    = 50;
    localparam int     ANGLE_SPAN_DEG = 180;
    localparam int     STEPS          = 4096;
    localparam int     MAX_COUNT      = 4095;
    localparam longint US_PER_S       = 1000000;
    localparam int     BASE_REG       = 6;
    localparam int     CENTI          = 100;
    localparam int     SLOTS          = 16;

    // field widths
    localparam int CMD_W      = 2;
    localparam int CH_W       = 4;
    localparam int VAL_W      = 21;
    localparam int ANG_W      = 9;
    localparam int PUL_W      = 15;
    localparam int CNT_W      = 12;
    localparam int ADDR_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // internal widths
    localparam int CENTI_W = 28;          // value * 100, signed
    localparam int ANGC_W  = 17;          // angle limit in centi-degrees
    localparam int D_W     = 16;          // offset above the lower angle limit
    localparam int DIFF_W  = PUL_W + 1;   // signed pulse range
    localparam int NUM_W   = 33;          // pulse numerator, signed
    localparam int T_W     = 56;          // scaled numerator plus half divisor, signed
    localparam int REM_W   = T_W - 1;     // magnitude of the scaled numerator
    localparam int REC_W   = CNT_W + 2;   // reciprocal of a divisor
    localparam int QE_W    = CNT_W + 1;   // quotient estimate, at most one too high

    // derived scaling
    localparam longint SPAN_C    = longint'(ANGLE_SPAN_DEG) * CENTI;
    localparam longint ANGLE_DEN = SPAN_C * US_PER_S;
    localparam longint PULSE_DEN = US_PER_S;
    localparam longint NUM_MUL   = longint'(PWM_FREQ_HZ) * STEPS;

    // numerator at or above these limits saturates the count
    localparam longint ANGLE_LIM = ANGLE_DEN * STEPS;
    localparam longint PULSE_LIM = PULSE_DEN * STEPS;

    // reciprocal scaling: below the limit the estimate is the quotient or one more
    localparam int     KA        = $clog2(ANGLE_LIM);
    localparam int     KP        = $clog2(PULSE_LIM);
    localparam longint ANGLE_REC = ((longint'(1) << KA) + ANGLE_DEN - 1) / ANGLE_DEN;
    localparam longint PULSE_REC = ((longint'(1) << KP) + PULSE_DEN - 1) / PULSE_DEN;

    localparam logic signed [CENTI_W-1:0] CENTI_S      = CENTI_W'(CENTI);
    localparam logic        [ANGC_W-1:0]  CENTI_U      = ANGC_W'(CENTI);
    localparam logic signed [NUM_W-1:0]   SPAN_S       = NUM_W'(SPAN_C);
    localparam logic signed [T_W-1:0]     NUM_MUL_T    = T_W'(NUM_MUL);
    localparam logic signed [T_W-1:0]     ANGLE_HALF_T = T_W'(ANGLE_DEN / 2);
    localparam logic signed [T_W-1:0]     PULSE_HALF_T = T_W'(PULSE_DEN / 2);
    localparam logic        [REM_W-1:0]   ANGLE_DEN_R  = REM_W'(ANGLE_DEN);
    localparam logic        [REM_W-1:0]   PULSE_DEN_R  = REM_W'(PULSE_DEN);
    localparam logic        [REM_W-1:0]   ANGLE_LIM_R  = REM_W'(ANGLE_LIM);
    localparam logic        [REM_W-1:0]   PULSE_LIM_R  = REM_W'(PULSE_LIM);
    localparam logic        [REC_W-1:0]   ANGLE_REC_C  = REC_W'(ANGLE_REC);
    localparam logic        [REC_W-1:0]   PULSE_REC_C  = REC_W'(PULSE_REC);
    localparam logic        [CNT_W-1:0]   COUNT_SAT    = CNT_W'(MAX_COUNT);
    localparam logic        [ADDR_W-1:0]  BASE_ADDR    = ADDR_W'(BASE_REG);

    // register reset values
    localparam logic [ANG_W-1:0] RST_MIN_ANGLE = ANG_W'(0);
    localparam logic [ANG_W-1:0] RST_MAX_ANGLE = ANG_W'(180);
    localparam logic [PUL_W-1:0] RST_PULSE_MIN = PUL_W'(500);
    localparam logic [PUL_W-1:0] RST_PULSE_MAX = PUL_W'(2500);

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_CENTI = 2'd0,
        CMD_DEG   = 2'd1,
        CMD_PULSE = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_ANGLE = 2'd0,
        CFG_MAX_ANGLE = 2'd1,
        CFG_PULSE_MIN = 2'd2,
        CFG_PULSE_MAX = 2'd3
    } t_cfg_idx;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic put;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic special;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

/* src/sapc_ifs.sv */
// sapc channel interfaces: command word in, result word out
// depends on sapc_pkg for the field widths
interface sapc_cmd_if import sapc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic [CH_W-1:0]         channel;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output command, output channel, output value, input ready);
    modport sink   (input valid, input command, input channel, input value, output ready);
endinterface

interface sapc_res_if import sapc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              write_needed;
    logic [ADDR_W-1:0] reg_address;
    logic [CNT_W-1:0]  off_count;
    logic              bad_channel;

    modport source (output valid, output write_needed, output reg_address,
                    output off_count, output bad_channel, input ready);
    modport sink   (input valid, input write_needed, input reg_address,
                    input off_count, input bad_channel, output ready);
endinterface

/* src/servo_angle_to_pwm_count.sv */
// servo_angle_to_pwm_count: top level, servo command word to pwm off-count word
// depends on sapc_pkg, sapc_ifs, sapc_ctrl, sapc_datapath (with sapc_div)
//
// Channels: i_cmd carries command (centi-degrees, whole degrees or pulse in us),
// channel and a signed value; o_res carries write_needed, reg_address, off_count
// and bad_channel. Both use valid/ready, a word moving when both are high.
// The register port (i_cfg_we, i_cfg_idx, i_cfg_data) sets the angle limits
// and the pulse range; write it only while no word is in flight.
// Path: a mapped word passes four mapping stages and then the divider, which
// estimates the quotient by a reciprocal and corrects it; an unused command code
// or a bad channel goes from the first stage straight to the result register.
// A new word is taken only once the last one is loaded into the output register.
// The result sits in an output register, so a stalled receiver holds one
// finished word while the next word is taken and mapped; that word then waits
// in the last step until the output register is free.
// Reset restores the register defaults and marks every channel's cached count
// as empty, so the first count for each channel always asks for a write.
module servo_angle_to_pwm_count import sapc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    sapc_cmd_if.sink              i_cmd,
    sapc_res_if.source            o_res
);

    t_ctrl_cmd  ctrl;
    t_dp_status status;
    logic       in_ready;

    // sequencer
    sapc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_ctrl     (ctrl)
    );

    assign i_cmd.ready = in_ready;

    // mapping, cache and result register
    sapc_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_command  (i_cmd.command),
        .i_channel  (i_cmd.channel),
        .i_value    (i_cmd.value),
        .i_ctrl     (ctrl),
        .o_status   (status),
        .o_res      (o_res)
    );

endmodule

/* src/sapc_div.sv */
// sapc_div: division by one of two constant divisors, reciprocal estimate then one correction
// depends on sapc_pkg; saturates the quotient to the 12-bit count range
module sapc_div import sapc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_sel_pulse,
    input  logic signed [T_W-1:0] i_t,
    output logic                 o_done,
    output logic [CNT_W-1:0]     o_count
);

    logic             r_neg;
    logic             r_sat;
    logic             r_sel;
    logic [KA-1:0]    r_tm;
    logic [QE_W-1:0]  r_qe;
    logic [REM_W-1:0] r_back;
    logic [CNT_W-1:0] r_q;
    logic [2:0]       r_step;
    logic             r_done;

    logic [REM_W-1:0]    t_mag;
    logic [KA+REC_W-1:0] prod_a;
    logic [KP+REC_W-1:0] prod_p;
    logic [QE_W-1:0]     qe_n;
    logic [REM_W-1:0]    den;

    assign t_mag  = REM_W'(i_t);
    assign prod_a = (KA + REC_W)'(r_tm) * (KA + REC_W)'(ANGLE_REC_C);
    assign prod_p = (KP + REC_W)'(r_tm[KP-1:0]) * (KP + REC_W)'(PULSE_REC_C);
    assign qe_n   = r_sel ? prod_p[KP +: QE_W] : prod_a[KA +: QE_W];
    assign den    = r_sel ? PULSE_DEN_R : ANGLE_DEN_R;

    // step sequence: capture, estimate, multiply back, correct
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_step <= {r_step[1:0], i_start};
            r_done <= r_step[2];
        end
    end

    // numerator magnitude, estimate, product and corrected quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_t[T_W-1];
            r_sat <= t_mag >= (i_sel_pulse ? PULSE_LIM_R : ANGLE_LIM_R);
            r_sel <= i_sel_pulse;
            r_tm  <= t_mag[KA-1:0];
        end
        if (r_step[0]) begin
            r_qe <= qe_n;
        end
        if (r_step[1]) begin
            r_back <= REM_W'(r_qe) * den;
        end
        if (r_step[2]) begin
            r_q <= (r_back > REM_W'(r_tm)) ? CNT_W'(r_qe - QE_W'(1)) : CNT_W'(r_qe);
        end
    end

    assign o_done  = r_done;
    assign o_count = r_neg ? '0 : (r_sat ? COUNT_SAT : r_q);

    // only one division is ever in progress
    a_step_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_step))
        else $error("divider steps overlap");

    // the quotient is ready once the start has passed every step through the correction
    a_start_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##4 r_done)
        else $error("divider done not four cycles after start");

endmodule

/* src/sapc_datapath.sv */
// sapc_datapath: configuration registers, mapping stages, divider, count cache, result register
// depends on sapc_pkg, sapc_res_if and sapc_div
module sapc_datapath import sapc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [CMD_W-1:0]        i_command,
    input  logic [CH_W-1:0]         i_channel,
    input  logic signed [VAL_W-1:0] i_value,
    input  t_ctrl_cmd               i_ctrl,
    output t_dp_status              o_status,
    sapc_res_if.source              o_res
);

    // configuration
    logic [ANG_W-1:0] r_min_ang;
    logic [ANG_W-1:0] r_max_ang;
    logic [PUL_W-1:0] r_pmin;
    logic [PUL_W-1:0] r_pmax;

    // input word
    t_cmd                    r_cmd;
    logic [CH_W-1:0]         r_ch;
    logic signed [VAL_W-1:0] r_val;

    // mapping stages
    logic signed [CENTI_W-1:0] r_centi;
    logic [PUL_W-1:0]          r_pulse;
    logic [D_W-1:0]            r_d;
    logic signed [DIFF_W-1:0]  r_diff;
    logic signed [NUM_W-1:0]   r_num;
    logic signed [T_W-1:0]     r_t;

    // count cache
    logic [CNT_W-1:0] r_last [SLOTS];
    logic [SLOTS-1:0] r_cvalid;

    // result register
    logic              r_ovalid;
    logic              r_wr;
    logic [ADDR_W-1:0] r_addr;
    logic [CNT_W-1:0]  r_count;
    logic              r_bad;

    logic                      sel_pulse;
    logic signed [CENTI_W-1:0] centi_n;
    logic signed [VAL_W:0]     v_x;
    logic signed [VAL_W:0]     pmin_x;
    logic signed [VAL_W:0]     pmax_x;
    logic signed [VAL_W:0]     p1;
    logic signed [VAL_W:0]     p2;
    logic [ANGC_W-1:0]         cmin_u;
    logic [ANGC_W-1:0]         cmax_u;
    logic signed [CENTI_W-1:0] cmin_s;
    logic signed [CENTI_W-1:0] cmax_s;
    logic signed [CENTI_W-1:0] c1;
    logic signed [CENTI_W-1:0] c2;
    logic signed [CENTI_W-1:0] dd;
    logic signed [NUM_W-1:0]   angle_num;
    logic                      div_done;
    logic [CNT_W-1:0]          div_count;
    logic                      is_none;
    logic                      is_bad;
    logic                      hit;
    logic                      out_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ang <= RST_MIN_ANGLE;
            r_max_ang <= RST_MAX_ANGLE;
            r_pmin    <= RST_PULSE_MIN;
            r_pmax    <= RST_PULSE_MAX;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MIN_ANGLE: r_min_ang <= ANG_W'(i_cfg_data);
                CFG_MAX_ANGLE: r_max_ang <= ANG_W'(i_cfg_data);
                CFG_PULSE_MIN: r_pmin    <= PUL_W'(i_cfg_data);
                CFG_PULSE_MAX: r_pmax    <= PUL_W'(i_cfg_data);
            endcase
        end
    end

    // capture the command word
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd <= t_cmd'(i_command);
            r_ch  <= i_channel;
            r_val <= i_value;
        end
    end

    assign sel_pulse = (r_cmd == CMD_PULSE);

    // stage 1: whole degrees to centi-degrees, pulse clamped to its range
    assign centi_n = (r_cmd == CMD_DEG) ? (CENTI_W'(r_val) * CENTI_S) : CENTI_W'(r_val);
    assign v_x     = (VAL_W + 1)'(r_val);
    assign pmin_x  = $signed((VAL_W + 1)'(r_pmin));
    assign pmax_x  = $signed((VAL_W + 1)'(r_pmax));
    assign p1      = (v_x < pmin_x) ? pmin_x : v_x;
    assign p2      = (p1 > pmax_x) ? pmax_x : p1;

    // stage 2: angle clamped, taken as offset above the lower limit
    assign cmin_u = ANGC_W'(r_min_ang) * CENTI_U;
    assign cmax_u = ANGC_W'(r_max_ang) * CENTI_U;
    assign cmin_s = $signed(CENTI_W'(cmin_u));
    assign cmax_s = $signed(CENTI_W'(cmax_u));
    assign c1     = (r_centi > cmax_s) ? cmax_s : r_centi;
    assign c2     = (c1 < cmin_s) ? cmin_s : c1;
    assign dd     = c2 - cmin_s;

    // stage 3: pulse numerator over the angle span
    assign angle_num = $signed(NUM_W'(r_pmin)) * SPAN_S
                     + $signed(NUM_W'(r_d)) * NUM_W'(r_diff);

    always_ff @(posedge i_clk) begin
        r_centi <= centi_n;
        r_pulse <= PUL_W'(p2);
        r_d     <= D_W'(dd);
        r_diff  <= $signed({1'b0, r_pmax}) - $signed({1'b0, r_pmin});
        r_num   <= sel_pulse ? $signed(NUM_W'(r_pulse)) : angle_num;
        // stage 4: scale to steps per period and add half the divisor
        r_t     <= T_W'(r_num) * NUM_MUL_T + (sel_pulse ? PULSE_HALF_T : ANGLE_HALF_T);
    end

    // rounding division and saturation
    sapc_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_ctrl.div_start),
        .i_sel_pulse (sel_pulse),
        .i_t         (r_t),
        .o_done      (div_done),
        .o_count     (div_count)
    );

    // result classification and cache lookup
    assign is_none  = (r_cmd == CMD_NONE);
    assign is_bad   = int'(r_ch) >= CHANNEL_COUNT;
    assign hit      = r_cvalid[r_ch] && (r_last[r_ch] == div_count);
    assign out_free = !r_ovalid || o_res.ready;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctrl.put) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.put) begin
            r_wr    <= 1'b0;
            r_addr  <= '0;
            r_count <= '0;
            r_bad   <= 1'b0;
            if (!is_none) begin
                if (is_bad) begin
                    r_bad <= 1'b1;
                end else begin
                    r_wr    <= !hit;
                    r_addr  <= BASE_ADDR + ADDR_W'({r_ch, 2'b00});
                    r_count <= div_count;
                end
            end
        end
    end

    // cache of the last count written per channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cvalid <= '0;
        end else if (i_ctrl.put && !is_none && !is_bad && !hit) begin
            r_cvalid[r_ch] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.put && !is_none && !is_bad && !hit) begin
            r_last[r_ch] <= div_count;
        end
    end

    assign o_status.special  = is_none || is_bad;
    assign o_status.div_done = div_done;
    assign o_status.out_free = out_free;

    assign o_res.valid        = r_ovalid;
    assign o_res.write_needed = r_wr;
    assign o_res.reg_address  = r_addr;
    assign o_res.off_count    = r_count;
    assign o_res.bad_channel  = r_bad;

    // a result is only loaded when the output register can take it
    a_put_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.put |-> out_free)
        else $error("result loaded over a word not yet taken");

    // a loaded result is offered in the following cycle
    a_put_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.put |=> r_ovalid)
        else $error("loaded result not offered");

    // a write request always leaves the channel marked in the cache
    a_cache_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.put && !is_none && !is_bad) |=> r_cvalid[$past(r_ch)])
        else $error("channel not marked after a count was issued");

endmodule

/* src/sapc_ctrl.sv */
// sapc_ctrl: sequencer for one command word through the mapping stages and the divider
// depends on sapc_pkg for the command and status structs
module sapc_ctrl import sapc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_ctrl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STG1,
        S_STG2,
        S_STG3,
        S_STG4,
        S_DWAIT,
        S_PUT
    } t_state;

    t_state r_state;
    logic   r_ready;
    logic   r_div_start;
    logic   accept;
    logic   put;

    assign accept = i_in_valid && r_ready;
    assign put    = (r_state == S_PUT) && i_status.out_free;

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ready     <= 1'b1;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_STG1;
                        r_ready <= 1'b0;
                    end
                end
                S_STG1: begin
                    r_state <= i_status.special ? S_PUT : S_STG2;
                end
                S_STG2: begin
                    r_state <= S_STG3;
                end
                S_STG3: begin
                    r_state <= S_STG4;
                end
                S_STG4: begin
                    r_state     <= S_DWAIT;
                    r_div_start <= 1'b1;
                end
                S_DWAIT: begin
                    if (i_status.div_done) begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (put) begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_in_ready       = r_ready;
    assign o_ctrl.load      = accept;
    assign o_ctrl.div_start = r_div_start;
    assign o_ctrl.put       = put;

    // a word is taken only while no other word is in flight
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !r_ready)
        else $error("ready raised while a word is in flight");

endmodule

/* bench/testbench.sv */
// testbench for servo_angle_to_pwm_count: random and directed servo command words,
// with results checked against a predictor of the angle/pulse to off-count mapping
// depends on sapc_pkg, sapc_ifs and the block under src
module testbench import sapc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_cmd                    command;
        logic [CH_W-1:0]         channel;
        logic signed [VAL_W-1:0] value;
    } t_servo_cmd;

    typedef struct packed {
        logic              write_needed;
        logic [ADDR_W-1:0] reg_address;
        logic [CNT_W-1:0]  off_count;
        logic              bad_channel;
    } t_servo_res;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sapc_cmd_if cmd_if ();
    sapc_res_if res_if ();

    servo_angle_to_pwm_count u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_if),
        .o_res      (res_if)
    );

    // predictor copy of the registers and the per-channel count cache
    logic [ANG_W-1:0] cfg_min_angle = RST_MIN_ANGLE;
    logic [ANG_W-1:0] cfg_max_angle = RST_MAX_ANGLE;
    logic [PUL_W-1:0] cfg_pulse_min = RST_PULSE_MIN;
    logic [PUL_W-1:0] cfg_pulse_max = RST_PULSE_MAX;
    logic [CNT_W-1:0] cached_count [SLOTS];
    bit               count_known  [SLOTS];

    t_servo_cmd queued_commands[$];
    t_servo_res awaited_results[$];
    t_servo_cmd offered;
    t_servo_cmd last_drawn = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_requests = 0;
    int stall_seen = 0;
    int stall_left = 0;
    int errors = 0;
    int accepted_count = 0;
    int suppressed_count = 0;
    int settings_count = 0;

    // fixed register settings for the first phase, extremes among them
    int fixed_min [8] = '{0, 360, 90, 0, 360, 0, 0, 45};
    int fixed_max [8] = '{360, 0, 90, 180, 360, 0, 180, 135};
    int fixed_pmin[8] = '{0, 20000, 1500, 2500, 20000, 0, 500, 600};
    int fixed_pmax[8] = '{20000, 0, 1500, 500, 20000, 0, 2500, 2400};

    always #5 i_clk = ~i_clk;

    // rounding half up, then saturation to the count range
    function automatic longint round_saturate(longint num, longint den);
        longint t;
        t = num + den / 2;
        if (t < 0) return 0;
        t = t / den;
        if (t > MAX_COUNT) t = MAX_COUNT;
        return t;
    endfunction

    function automatic longint angle_count(longint centi);
        longint lo;
        longint hi;
        longint span;
        longint num;
        lo   = longint'(cfg_min_angle) * CENTI;
        hi   = longint'(cfg_max_angle) * CENTI;
        span = longint'(ANGLE_SPAN_DEG) * CENTI;
        // upper limit first, so a crossed pair ends at the lower limit
        if (centi > hi) centi = hi;
        if (centi < lo) centi = lo;
        num = longint'(cfg_pulse_min) * span +
              (centi - lo) * (longint'(cfg_pulse_max) - longint'(cfg_pulse_min));
        return round_saturate(num * PWM_FREQ_HZ * STEPS, span * US_PER_S);
    endfunction

    function automatic longint pulse_count(longint p);
        // lower limit first, so a crossed pair ends at the upper limit
        if (p < longint'(cfg_pulse_min)) p = longint'(cfg_pulse_min);
        if (p > longint'(cfg_pulse_max)) p = longint'(cfg_pulse_max);
        return round_saturate(p * PWM_FREQ_HZ * STEPS, US_PER_S);
    endfunction

    // expected result word of one accepted command, updating the cache
    function automatic t_servo_res map_command(t_servo_cmd c);
        t_servo_res res;
        longint     v;
        longint     cnt;
        res = '0;
        if (c.command == CMD_NONE) return res;
        if (int'(c.channel) >= CHANNEL_COUNT) begin
            res.bad_channel = 1'b1;
            return res;
        end
        v = longint'($signed(c.value));
        case (c.command)
            CMD_CENTI: cnt = angle_count(v);
            CMD_DEG:   cnt = angle_count(v * CENTI);
            default:   cnt = pulse_count(v);
        endcase
        res.reg_address = ADDR_W'(BASE_REG + 4 * int'(c.channel));
        res.off_count   = CNT_W'(cnt);
        if (count_known[c.channel] && cached_count[c.channel] == res.off_count) begin
            res.write_needed = 1'b0;
            suppressed_count++;
        end else begin
            res.write_needed = 1'b1;
            cached_count[c.channel] = res.off_count;
            count_known[c.channel]  = 1'b1;
        end
        return res;
    endfunction

    // random command word: mostly plausible values, some full-range noise, some repeats
    function automatic t_servo_cmd random_command();
        t_servo_cmd c;
        int         r;
        if ($urandom_range(0, 99) < 20) return last_drawn;
        r = $urandom_range(0, 99);
        if (r < 5)       c.command = CMD_NONE;
        else if (r < 37) c.command = CMD_CENTI;
        else if (r < 68) c.command = CMD_DEG;
        else             c.command = CMD_PULSE;
        c.channel = CH_W'($urandom);
        if ($urandom_range(0, 99) < 10) begin
            c.value = VAL_W'($urandom);
        end else begin
            case (c.command)
                CMD_CENTI: c.value = VAL_W'(int'($urandom_range(0, 42000)) - 3000);
                CMD_DEG:   c.value = VAL_W'(int'($urandom_range(0, 420)) - 30);
                default:   c.value = VAL_W'(int'($urandom_range(0, 24000)) - 2000);
            endcase
        end
        last_drawn = c;
        return c;
    endfunction

    task automatic push_cmd(t_cmd cmd, int ch, int val);
        t_servo_cmd c;
        c.command = cmd;
        c.channel = CH_W'(ch);
        c.value   = VAL_W'(val);
        queued_commands.push_back(c);
    endtask

    task automatic load_commands(int n);
        @(negedge i_clk);
        repeat (n) queued_commands.push_back(random_command());
    endtask

    // nothing queued, nothing offered, nothing outstanding
    task automatic wait_drained();
        while (queued_commands.size() != 0 || cmd_if.valid || awaited_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx idx, int data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(data);
        case (idx)
            CFG_MIN_ANGLE: cfg_min_angle = ANG_W'(data);
            CFG_MAX_ANGLE: cfg_max_angle = ANG_W'(data);
            CFG_PULSE_MIN: cfg_pulse_min = PUL_W'(data);
            default:       cfg_pulse_max = PUL_W'(data);
        endcase
    endtask

    task automatic apply_setting(int amin, int amax, int pmin, int pmax);
        write_register(CFG_MIN_ANGLE, amin);
        write_register(CFG_MAX_ANGLE, amax);
        write_register(CFG_PULSE_MIN, pmin);
        write_register(CFG_PULSE_MAX, pmax);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_count++;
    endtask

    task automatic report_field(string name, longint want, longint got);
        errors++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endtask

    // driver: offer queued words, predict each one as it is accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                awaited_results.push_back(map_command(offered));
                accepted_count++;
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (queued_commands.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    offered = queued_commands.pop_front();
                    cmd_if.valid   <= 1'b1;
                    cmd_if.command <= offered.command;
                    cmd_if.channel <= offered.channel;
                    cmd_if.value   <= offered.value;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result word against the oldest prediction, drive ready
    always @(posedge i_clk) begin
        t_servo_res want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (awaited_results.size() == 0) begin
                    errors++;
                    $display("%0t ns: result word with none expected, actual addr %0d count %0d",
                             $time, res_if.reg_address, res_if.off_count);
                end else begin
                    want = awaited_results.pop_front();
                    if (res_if.write_needed !== want.write_needed)
                        report_field("write_needed", want.write_needed, res_if.write_needed);
                    if (res_if.reg_address !== want.reg_address)
                        report_field("reg_address", want.reg_address, res_if.reg_address);
                    if (res_if.off_count !== want.off_count)
                        report_field("off_count", want.off_count, res_if.off_count);
                    if (res_if.bad_channel !== want.bad_channel)
                        report_field("bad_channel", want.bad_channel, res_if.bad_channel);
                end
            end
            // long hold-off on request, random idling otherwise
            if (stall_seen != stall_requests) begin
                stall_seen = stall_requests;
                stall_left = 400;
                res_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // stimulus sequence
    initial begin
        int amin;
        int amax;
        int pmin;
        int pmax;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_MIN_ANGLE;
        i_cfg_data     = '0;
        cmd_if.valid   = 1'b0;
        cmd_if.command = CMD_CENTI;
        cmd_if.channel = '0;
        cmd_if.value   = '0;
        res_if.ready   = 1'b0;
        for (int i = 0; i < SLOTS; i++) count_known[i] = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 9;
        recv_idle_pct = 52;
        @(negedge i_clk);
        // directed words at the reset settings: field extremes, repeats, unused code
        push_cmd(CMD_CENTI, 0, 0);
        push_cmd(CMD_CENTI, 1, 18000);
        push_cmd(CMD_CENTI, 2, 9000);
        push_cmd(CMD_CENTI, 2, 9000);
        push_cmd(CMD_CENTI, 3, -1048576);
        push_cmd(CMD_CENTI, 4, 1048575);
        push_cmd(CMD_DEG, 5, 0);
        push_cmd(CMD_DEG, 6, 180);
        push_cmd(CMD_DEG, 7, 90);
        push_cmd(CMD_DEG, 8, -1048576);
        push_cmd(CMD_DEG, 9, 1048575);
        push_cmd(CMD_PULSE, 10, 500);
        push_cmd(CMD_PULSE, 11, 2500);
        push_cmd(CMD_PULSE, 12, 0);
        push_cmd(CMD_PULSE, 13, 1048575);
        push_cmd(CMD_PULSE, 14, -1048576);
        push_cmd(CMD_NONE, 15, -1);
        push_cmd(CMD_NONE, 0, 0);
        push_cmd(CMD_PULSE, 15, 1500);
        push_cmd(CMD_PULSE, 15, 1500);
        push_cmd(CMD_DEG, 0, 45);
        push_cmd(CMD_DEG, 6, 200);

        for (int phase = 0; phase < 3; phase++) begin
            for (int seg = 0; seg < 8; seg++) begin
                wait_drained();
                case (phase)
                    0: begin send_idle_pct = 9;  recv_idle_pct = 52; end
                    1: begin send_idle_pct = 52; recv_idle_pct = 9;  end
                    default: begin send_idle_pct = 0; recv_idle_pct = 0; end
                endcase
                if (phase == 0) begin
                    amin = fixed_min[seg];
                    amax = fixed_max[seg];
                    pmin = fixed_pmin[seg];
                    pmax = fixed_pmax[seg];
                end else begin
                    amin = ($urandom_range(0, 4) == 0) ? 360 * $urandom_range(0, 1)
                                                       : $urandom_range(0, 360);
                    amax = ($urandom_range(0, 4) == 0) ? 360 * $urandom_range(0, 1)
                                                       : $urandom_range(0, 360);
                    pmin = ($urandom_range(0, 4) == 0) ? 20000 * $urandom_range(0, 1)
                                                       : $urandom_range(0, 20000);
                    pmax = ($urandom_range(0, 4) == 0) ? 20000 * $urandom_range(0, 1)
                                                       : $urandom_range(0, 20000);
                end
                apply_setting(amin, amax, pmin, pmax);
                if (phase == 1 && seg == 3) begin
                    // sender pauses until every outstanding word has come back
                    load_commands(40);
                    wait_drained();
                    load_commands(40);
                end else begin
                    load_commands(80);
                    // receiver holds off while the sender keeps offering
                    if (phase == 2 && seg == 0) stall_requests++;
                end
            end
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("covered %0d command words over %0d register settings", accepted_count,
                 settings_count);
        $display("%0d repeated counts were expected to be suppressed", suppressed_count);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
